[rtl/core/indexed_sequence_store_unit_assert.svh]
// Assertion macros used by the port-level checker of the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define ISSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication form of the above.
`define ISSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication form of the above.
`define ISSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/issu_pkg.sv]
// Types and constants of the indexed sequence store.
package issu_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;

    localparam int OPCODE_W  = 3;
    localparam int POS_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 6;

    localparam int IN_FIELDS_W = OPCODE_W + 2 * POS_W + VALUE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_SWAP     = 3'd2,
        OP_READ_ALL = 3'd3,
        OP_READ_NZ  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_DEL,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_RD,
        S_RD_END,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  element;
        logic [LEN_W-1:0]           length;
        logic                       last;
    } t_result;

endpackage

[rtl/core/issu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module issu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/issu_ctrl.sv]
// Sequencer: validates each operation and walks the element memory.
module issu_ctrl
    import issu_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic [POS_W-1:0]           i_position,
    input  logic [POS_W-1:0]           i_second_position,
    input  logic [VALUE_W-1:0]         i_value,
    output logic                       o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [VALUE_W-1:0]         o_ram_wdata,
    output logic                       o_ram_re,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [VALUE_W-1:0]         i_ram_rdata,
    output logic                       o_res_valid,
    output t_result                    o_res,
    input  logic                       i_res_ready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_idx2, n_idx2;
    logic [AW-1:0]        r_pos, n_pos;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [VALUE_W-1:0]   r_tmp, n_tmp;
    t_status              r_status, n_status;
    logic                 r_hold_valid, n_hold_valid;
    logic [VALUE_W-1:0]   r_hold, n_hold;
    logic [NW-1:0]        r_nemit, n_nemit;
    logic                 r_nz, n_nz;

    logic [XW-1:0] p_x, q_x, cnt_x, cap_x, pm1_x, qm1_x, p1_x, cm1_x, idx1_x;
    logic [NW-1:0] nemit_nxt;
    logic          keep;

    assign p_x    = XW'(i_position);
    assign q_x    = XW'(i_second_position);
    assign cnt_x  = XW'(r_count);
    assign cap_x  = XW'(CAPACITY);
    assign pm1_x  = p_x - XW'(1);
    assign qm1_x  = q_x - XW'(1);
    assign p1_x   = p_x + XW'(1);
    assign cm1_x  = cnt_x - XW'(1);
    assign idx1_x = XW'(r_idx) + XW'(1);
    assign keep   = !r_nz || (i_ram_rdata != '0);
    assign nemit_nxt = keep ? (r_nemit + NW'(1)) : r_nemit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_idx2   <= n_idx2;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_tmp    <= n_tmp;
        r_status <= n_status;
        r_hold   <= n_hold;
        r_nemit  <= n_nemit;
        r_nz     <= n_nz;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_idx2       = r_idx2;
        n_pos        = r_pos;
        n_value      = r_value;
        n_tmp        = r_tmp;
        n_status     = r_status;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_nemit      = r_nemit;
        n_nz         = r_nz;

        o_in_ready   = (r_state == S_IDLE);
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_idx;
        o_ram_wdata  = r_value;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_idx;
        o_res_valid  = 1'b0;
        o_res.status  = r_status;
        o_res.element = '0;
        o_res.length  = LEN_W'(r_count);
        o_res.last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value      = i_value;
                    n_status     = ST_OK;
                    n_nz         = 1'b0;
                    n_hold_valid = 1'b0;
                    n_nemit      = '0;
                    n_state      = S_DONE;
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (p_x > cnt_x) begin
                                n_status = ST_BAD_INDEX;
                            end else if (cnt_x >= cap_x) begin
                                n_status = ST_FULL;
                            end else if (p_x == cnt_x) begin
                                n_pos   = p_x[AW-1:0];
                                n_state = S_INS_PUT;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = cm1_x[AW-1:0];
                                n_idx       = cm1_x[AW-1:0];
                                n_pos       = p_x[AW-1:0];
                                n_state     = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (p_x >= cnt_x) begin
                                n_status = ST_BAD_INDEX;
                            end else if (p_x == cm1_x) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = p1_x[AW-1:0];
                                n_idx       = p1_x[AW-1:0];
                                n_state     = S_DEL;
                            end
                        end
                        OP_SWAP: begin
                            if (p_x == '0 || p_x > cnt_x || q_x == '0 || q_x > cnt_x) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = pm1_x[AW-1:0];
                                n_idx       = pm1_x[AW-1:0];
                                n_idx2      = qm1_x[AW-1:0];
                                n_state     = S_SW_A;
                            end
                        end
                        OP_READ_ALL, OP_READ_NZ: begin
                            n_nz = (t_op'(i_opcode) == OP_READ_NZ);
                            if (r_count == '0) begin
                                n_state = S_RD_END;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = '0;
                                n_idx       = '0;
                                n_state     = S_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx + AW'(1);
                o_ram_wdata = i_ram_rdata;
                if (r_idx != r_pos) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx - AW'(1);
                    n_idx       = r_idx - AW'(1);
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos;
                o_ram_wdata = r_value;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_DEL: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx - AW'(1);
                o_ram_wdata = i_ram_rdata;
                if (idx1_x < cnt_x) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = idx1_x[AW-1:0];
                    n_idx       = idx1_x[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SW_A: begin
                n_tmp       = i_ram_rdata;
                o_ram_re    = 1'b1;
                o_ram_raddr = r_idx2;
                n_state     = S_SW_B;
            end
            S_SW_B: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx;
                o_ram_wdata = i_ram_rdata;
                n_state     = S_SW_C;
            end
            S_SW_C: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx2;
                o_ram_wdata = r_tmp;
                n_state     = S_DONE;
            end
            S_RD: begin
                if (!(keep && r_hold_valid && !i_res_ready)) begin
                    if (keep) begin
                        if (r_hold_valid) begin
                            o_res_valid   = 1'b1;
                            o_res.status  = ST_OK;
                            o_res.element = r_hold;
                            o_res.last    = 1'b0;
                        end
                        n_hold       = i_ram_rdata;
                        n_hold_valid = 1'b1;
                    end
                    n_nemit = nemit_nxt;
                    if (idx1_x < cnt_x && nemit_nxt < NW'(MAX_RESULTS)) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = idx1_x[AW-1:0];
                        n_idx       = idx1_x[AW-1:0];
                    end else begin
                        n_state = S_RD_END;
                    end
                end
            end
            S_RD_END: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    if (r_hold_valid) begin
                        o_res.status  = ST_OK;
                        o_res.element = r_hold;
                    end else begin
                        o_res.status  = ST_EMPTY;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/issu_out.sv]
// Output register between the sequencer and the result stream.
module issu_out
    import issu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    input  t_result                i_res,
    output logic                   o_res_ready,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_m_axis_tready;
    assign n_valid     = i_res_valid || (r_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_res.length, r_res.element, r_res.status});
    assign o_m_axis_tlast  = r_res.last;

endmodule

[rtl/core/indexed_sequence_store_unit.sv]
// Indexed sequence store: bounded ordered list of signed words with insert,
// delete, swap and readout operations.
//
// Input stream: one transfer per operation (opcode, position, second
// position, value). Output stream: one result per operation, or one per
// emitted word for a readout, tlast on the final one.
// The block takes one operation at a time; o_s_axis_tready is high only
// while the sequencer is idle, even when a result still waits at the output.
// All words live in one RAM with registered read data, a single read port and
// a single write port. An insert at p moves the words from the end down to p
// up by one, then writes the value; an append writes it directly. A delete at
// p moves the words above p down by one; a last-element delete only lowers the
// count. A swap reads both words and writes each to the other's place. A
// readout reads one word per cycle while the output does not stall, up to 32
// words emitted. Each result passes through the output register.
// A stalled receiver holds the output register; the walk then pauses and
// resumes without loss. Reset empties the list; RAM contents are not cleared
// since only entries below the count are ever read.
module indexed_sequence_store_unit
    import issu_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // opcode[2:0], position[8:3], second_position[14:9], value[46:15], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[1:0], element[33:2], length[39:34]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]  ram_wdata, ram_rdata;
    logic                res_valid, res_ready;
    t_result             res;

    issu_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_s_axis_tvalid),
        .o_in_ready        (o_s_axis_tready),
        .i_opcode          (i_s_axis_tdata[OPCODE_W-1:0]),
        .i_position        (i_s_axis_tdata[OPCODE_W+POS_W-1:OPCODE_W]),
        .i_second_position (i_s_axis_tdata[OPCODE_W+2*POS_W-1:OPCODE_W+POS_W]),
        .i_value           (i_s_axis_tdata[IN_FIELDS_W-1:OPCODE_W+2*POS_W]),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_re          (ram_re),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata),
        .o_res_valid       (res_valid),
        .o_res             (res),
        .i_res_ready       (res_ready)
    );

    issu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    issu_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (res_valid),
        .i_res           (res),
        .o_res_ready     (res_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[rtl/core/issu_chk.sv]
// Port-level checker for the indexed sequence store, bound to the top level.
`include "indexed_sequence_store_unit_assert.svh"

module issu_chk
    import issu_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);

    logic in_xfer;
    logic out_empty;
    logic out_err;

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_empty = o_m_axis_tvalid && (t_status'(o_m_axis_tdata[1:0]) == ST_EMPTY);
    assign out_err   = o_m_axis_tvalid &&
                       ((t_status'(o_m_axis_tdata[1:0]) == ST_BAD_INDEX) ||
                        (t_status'(o_m_axis_tdata[1:0]) == ST_FULL));

    `ISSU_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output changed")
    `ISSU_ASSERT_NXT(a_one_op, in_xfer, !o_s_axis_tready, "second operation taken while busy")
    `ISSU_ASSERT_IMP(a_empty_single, out_empty, o_m_axis_tlast && (o_m_axis_tdata[33:2] == '0), "empty readout not a single zero result")
    `ISSU_ASSERT_IMP(a_err_single, out_err, o_m_axis_tlast && (o_m_axis_tdata[33:2] == '0), "rejected operation not a single zero result")

endmodule

bind indexed_sequence_store_unit issu_chk u_chk (.*);

[dv/store_result_checker.sv]
// Checker for the sequence store: mirrors the stored list and compares every output transfer.
module store_result_checker
    import issu_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    // opcode, position, second_position, value, zero pad
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    // status, element, length
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  logic                   i_out_tlast,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int POS_LSB    = OPCODE_W;
    localparam int SECOND_LSB = OPCODE_W + POS_W;
    localparam int VALUE_LSB  = OPCODE_W + 2 * POS_W;
    localparam int WORD_LSB   = STATUS_W;
    localparam int LEN_LSB    = STATUS_W + VALUE_W;

    logic signed [VALUE_W-1:0] list_words [CAPACITY];
    int                        list_len = 0;
    t_result                   outputs_due [$];
    int                        fail_total = 0;
    int                        checked_total = 0;

    function automatic void owe_output(t_status st, logic signed [VALUE_W-1:0] word, logic fin);
        t_result r;
        r.status  = st;
        r.element = word;
        r.length  = LEN_W'(list_len);
        r.last    = fin;
        outputs_due.insert(outputs_due.size(), r);
    endfunction

    function automatic void read_out(logic nonzero_only);
        int                        emitted;
        logic                      held;
        logic signed [VALUE_W-1:0] held_word;
        emitted   = 0;
        held      = 1'b0;
        held_word = '0;
        for (int k = 0; k < list_len && emitted < MAX_RESULTS; k++) begin
            if (!(nonzero_only && list_words[k] == '0)) begin
                if (held)
                    owe_output(ST_OK, held_word, 1'b0);
                held      = 1'b1;
                held_word = list_words[k];
                emitted++;
            end
        end
        if (held)
            owe_output(ST_OK, held_word, 1'b1);
        else
            owe_output(ST_EMPTY, '0, 1'b1);
    endfunction

    function automatic void apply_list_op(logic [OPCODE_W-1:0] op, int p, int q,
                                          logic signed [VALUE_W-1:0] v);
        t_status                   st;
        logic signed [VALUE_W-1:0] t;
        st = ST_OK;
        case (op)
            OP_INSERT: begin
                if (p > list_len) begin
                    st = ST_BAD_INDEX;
                end else if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    for (int k = list_len; k > p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p] = v;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p >= list_len) begin
                    st = ST_BAD_INDEX;
                end else begin
                    for (int k = p; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            OP_SWAP: begin
                if (p < 1 || p > list_len || q < 1 || q > list_len) begin
                    st = ST_BAD_INDEX;
                end else begin
                    t               = list_words[p-1];
                    list_words[p-1] = list_words[q-1];
                    list_words[q-1] = t;
                end
            end
            OP_READ_ALL: begin
                read_out(1'b0);
                return;
            end
            OP_READ_NZ: begin
                read_out(1'b1);
                return;
            end
            default: ;
        endcase
        owe_output(st, '0, 1'b1);
    endfunction

    function automatic void report_field(string field, logic [VALUE_W-1:0] want,
                                         logic [VALUE_W-1:0] got);
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
        fail_total++;
    endfunction

    function automatic void check_output();
        t_result                   want;
        t_status                   got_status;
        logic signed [VALUE_W-1:0] got_word;
        logic [LEN_W-1:0]          got_len;
        got_status = t_status'(i_out_tdata[0 +: STATUS_W]);
        got_word   = i_out_tdata[WORD_LSB +: VALUE_W];
        got_len    = i_out_tdata[LEN_LSB +: LEN_W];
        if (outputs_due.size() == 0) begin
            $display("%0t: transfer expected none actual tdata 0x%0h tlast %0b",
                     $time, i_out_tdata, i_out_tlast);
            fail_total++;
            return;
        end
        want = outputs_due.pop_front();
        checked_total++;
        if (want.status !== got_status)
            report_field("status", want.status, got_status);
        if (want.element !== got_word)
            report_field("element", want.element, got_word);
        if (want.length !== got_len)
            report_field("length", want.length, got_len);
        if (want.last !== i_out_tlast)
            report_field("tlast", want.last, i_out_tlast);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            outputs_due.delete();
        end else begin
            if (i_in_tvalid && i_in_tready)
                apply_list_op(i_in_tdata[0 +: OPCODE_W],
                              int'(i_in_tdata[POS_LSB +: POS_W]),
                              int'(i_in_tdata[SECOND_LSB +: POS_W]),
                              i_in_tdata[VALUE_LSB +: VALUE_W]);
            if (i_out_tvalid && i_out_tready)
                check_output();
        end
        o_pending    <= outputs_due.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

[dv/tb_indexed_sequence_store_unit.sv]
// Testbench top for the sequence store: clock, reset, stimulus, output pacing and verdict.
module tb_indexed_sequence_store_unit;
    import issu_pkg::*;

    localparam int ITEM_TARGET      = 460;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 40;

    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [VALUE_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_ONES = 32'hffff_ffff;

    typedef enum int {PICK_INSERT, PICK_DELETE, PICK_SWAP, PICK_READ, PICK_NOISE} t_pick;
    typedef enum int {VALUES_RANDOM, VALUES_ZERO, VALUES_CORNER} t_value_mix;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // opcode[2:0], position[8:3], second_position[14:9], value[46:15], zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // status[1:0], element[33:2], length[39:34]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    int fail_count;
    int results_pending;
    int results_checked;

    bit calm = 1'b0;
    int hold_requests = 0;
    int list_len = 0;
    int ops_sent = 0;
    int inserts_sent = 0;
    int deletes_sent = 0;
    int swaps_sent = 0;
    int reads_sent = 0;
    int spares_sent = 0;
    int full_hits = 0;

    indexed_sequence_store_unit #(
        .CAPACITY(CAPACITY_DEF)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    store_result_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) u_store_result_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (i_s_axis_tvalid),
        .i_in_tready (o_s_axis_tready),
        .i_in_tdata  (i_s_axis_tdata),
        .i_out_tvalid(o_m_axis_tvalid),
        .i_out_tready(i_m_axis_tready),
        .i_out_tdata (o_m_axis_tdata),
        .i_out_tlast (o_m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending   (results_pending),
        .o_checked   (results_checked)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #12_000_000;
        $display("indexed_sequence_store_unit: mismatch");
        $finish;
    end

    // Pace the output side: random stall per transfer, plus requested long holds.
    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (hold_requests > 0) begin
                hold_requests--;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value(t_value_mix mix);
        case (mix)
            VALUES_ZERO:
                return ($urandom_range(0, 7) == 0) ? $urandom : '0;
            VALUES_CORNER: begin
                case ($urandom_range(0, 5))
                    0: return '0;
                    1: return WORD_MAX;
                    2: return WORD_MIN;
                    3: return WORD_ONES;
                    4: return 32'd1;
                    default: return $urandom;
                endcase
            end
            default:
                return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] p,
                           input logic [POS_W-1:0] q, input logic [VALUE_W-1:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, v, q, p, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ops_sent++;
        case (op)
            OP_INSERT: begin
                inserts_sent++;
                if (p <= list_len && list_len == CAPACITY_DEF)
                    full_hits++;
                else if (p <= list_len)
                    list_len++;
            end
            OP_DELETE: begin
                deletes_sent++;
                if (p < list_len)
                    list_len--;
            end
            OP_SWAP: swaps_sent++;
            OP_READ_ALL, OP_READ_NZ: reads_sent++;
            default: spares_sent++;
        endcase
    endtask

    task automatic send_pick(input t_pick pick, input t_value_mix mix);
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    p;
        logic [POS_W-1:0]    q;
        p = POS_W'($urandom);
        q = POS_W'($urandom);
        case (pick)
            PICK_INSERT: begin
                op = OP_INSERT;
                if ($urandom_range(0, 9) != 0)
                    p = POS_W'($urandom_range(0, list_len));
            end
            PICK_DELETE: begin
                op = OP_DELETE;
                if (list_len > 0 && $urandom_range(0, 9) != 0)
                    p = POS_W'($urandom_range(0, list_len - 1));
            end
            PICK_SWAP: begin
                op = OP_SWAP;
                if (list_len > 0 && $urandom_range(0, 9) != 0) begin
                    p = POS_W'($urandom_range(1, list_len));
                    q = POS_W'($urandom_range(1, list_len));
                end
            end
            PICK_READ:
                op = $urandom_range(0, 1) ? OP_READ_ALL : OP_READ_NZ;
            default:
                op = OPCODE_W'($urandom);
        endcase
        send_op(op, p, q, pick_value(mix));
    endtask

    // Hold the input side until every owed result has been transferred.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int         phase_kind;
        int         burst;
        t_value_mix mix;
        t_pick      pick;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(OP_READ_ALL, '0, '0, '0);
        send_op(OP_READ_NZ, '0, '0, '0);
        send_op(OP_DELETE, 6'd0, '0, '0);
        send_op(OP_SWAP, 6'd1, 6'd1, '0);
        send_op(OP_INSERT, 6'd1, '0, WORD_ONES);
        send_op(OP_INSERT, 6'd0, '0, WORD_MAX);
        send_op(OP_INSERT, 6'd1, '0, WORD_MIN);
        send_op(OP_INSERT, 6'd0, '0, '0);
        send_op(OP_INSERT, 6'd2, '0, WORD_ONES);
        send_op(OP_READ_NZ, '0, '0, '0);
        send_op(OP_SWAP, 6'd1, 6'd4, '0);
        send_op(OP_SWAP, 6'd3, 6'd3, '0);
        send_op(OP_SWAP, 6'd0, 6'd2, '0);
        send_op(OP_SWAP, 6'd2, 6'd5, '0);
        send_op(OP_SWAP, 6'd63, 6'd63, WORD_ONES);
        send_op(OP_INSERT, 6'd63, 6'd63, WORD_ONES);
        send_op(OP_DELETE, 6'd63, 6'd63, WORD_ONES);
        send_op(OP_READ_ALL, 6'd63, 6'd63, WORD_ONES);
        send_op(OP_DELETE, 6'd2, '0, '0);
        send_op(OP_DELETE, 6'd1, '0, '0);
        send_op(OP_DELETE, 6'd0, '0, '0);
        send_op(OP_READ_NZ, '0, '0, '0);
        send_op(OP_SPARE_FIRST, 6'd63, 6'd63, WORD_ONES);
        send_op(OP_SPARE_FIRST + 3'd1, 6'd5, 6'd9, $urandom);
        send_op(OP_SPARE_LAST, '0, '0, '0);

        // Fill to capacity, then read back while the output side holds off.
        while (list_len < CAPACITY_DEF) send_pick(PICK_INSERT, VALUES_RANDOM);
        hold_requests++;
        send_op(OP_READ_ALL, '0, '0, '0);
        repeat (3) send_pick(PICK_INSERT, VALUES_CORNER);
        send_op(OP_READ_NZ, '0, '0, '0);
        drain_results();

        while (ops_sent < ITEM_TARGET) begin
            phase_kind = $urandom_range(0, 9);
            mix        = t_value_mix'($urandom_range(0, 2));
            burst      = $urandom_range(4, 24);
            calm       = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                case (phase_kind)
                    0, 1, 2: pick = ($urandom_range(0, 5) == 0) ? PICK_READ : PICK_INSERT;
                    3, 4:    pick = PICK_DELETE;
                    5, 6:    pick = ($urandom_range(0, 3) == 0) ? PICK_READ : PICK_SWAP;
                    9:       pick = PICK_NOISE;
                    default: pick = t_pick'($urandom_range(0, 4));
                endcase
                send_pick(pick, mix);
            end
            send_pick(PICK_READ, mix);
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations: %0d insert, %0d delete, %0d swap, %0d readout, %0d spare",
                 ops_sent, inserts_sent, deletes_sent, swaps_sent, reads_sent, spares_sent);
        $display("Inserts into a full list: %0d; output transfers checked: %0d",
                 full_hits, results_checked);
        if (fail_count == 0 && results_pending == 0)
            $display("indexed_sequence_store_unit: match");
        else
            $display("indexed_sequence_store_unit: mismatch");
        $finish;
    end

endmodule
